FILE: src/motion_priority_source_selector_core_assert.svh
// Assertion macros shared by the selector modules.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef MOTION_PRIORITY_SOURCE_SELECTOR_CORE_ASSERT_SVH
`define MOTION_PRIORITY_SOURCE_SELECTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MPSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPSS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define MPSS_ASSERT(lbl, prop, msg)
`define MPSS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

FILE: src/mpss_pkg.sv
package mpss_pkg;

    localparam int NUM_SOURCES = 16;
    localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SRC_W       = 4;
    localparam int AMT_W       = 24;
    localparam int FRAC_W      = 8;
    localparam int CNT_W       = AMT_W - FRAC_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [0:0] {
        OP_MARK   = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic update;
        logic scan;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_last;
    } dp_status_t;

endpackage

FILE: src/mpss_ctrl.sv
`include "motion_priority_source_selector_core_assert.svh"

module mpss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mpss_pkg::dp_status_t status,
    output logic                busy,
    output logic                done,
    output mpss_pkg::ctrl_cmd_t cmd
);
    import mpss_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // a new beat may also be taken while the result is on the ports
    assign accept = start && ((state_reg == ST_IDLE) || (state_reg == ST_DONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_UPDATE : ST_IDLE;
            ST_UPDATE: state_next = ST_SCAN;
            ST_SCAN:   state_next = status.scan_last ? ST_FLUSH : ST_SCAN;
            ST_FLUSH:  state_next = ST_DONE;
            ST_DONE:   state_next = accept ? ST_UPDATE : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = !(state_reg inside {ST_IDLE, ST_DONE});
        done       = (state_reg == ST_DONE);
        cmd.load   = accept;
        cmd.update = (state_reg == ST_UPDATE);
        cmd.scan   = (state_reg == ST_SCAN);
    end

    `MPSS_ASSERT(a_done_single, done |=> !done, "result strobe held over two cycles")
    `MPSS_ASSERT(a_accept_update, (start && !busy) |=> (state_reg == ST_UPDATE),
        "accepted beat did not start an update")
    `MPSS_ASSERT_IMPL(a_scan_end, (state_reg == ST_SCAN) && status.scan_last,
        ##1 (state_reg == ST_FLUSH), "scan did not stop at the last entry")

endmodule

FILE: src/mpss_datapath.sv
`include "motion_priority_source_selector_core_assert.svh"

module mpss_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mpss_pkg::ctrl_cmd_t           cmd,
    input  logic                          opcode,
    input  logic [mpss_pkg::SRC_W-1:0]    source_id,
    input  logic [mpss_pkg::AMT_W-1:0]    motion_amount,
    output mpss_pkg::dp_status_t          status,
    output logic [mpss_pkg::SRC_W-1:0]    top_source,
    output logic                          table_empty
);
    import mpss_pkg::*;

    // latched beat
    opcode_t              op_reg;
    logic [SRC_W-1:0]     id_reg;
    logic [AMT_W-1:0]     amt_reg;

    logic [AMT_W-1:0]     amount_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic [IDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [AMT_W-1:0]     rd_amt_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_pend_reg, rd_pend_next;

    logic [AMT_W-1:0]     best_amt_reg, best_amt_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic                 found_reg, found_next;

    logic                 in_range;
    logic [IDX_W-1:0]     wr_idx;
    logic                 int_zero;
    logic [CNT_W-1:0]     cnt_inc;
    logic [AMT_W-1:0]     stored_amt;
    logic                 scan_last;
    logic                 take;

    assign in_range   = int'(id_reg) < NUM_SOURCES;
    assign wr_idx     = IDX_W'(id_reg);
    assign int_zero   = (amt_reg[AMT_W-1:FRAC_W] == '0);
    assign cnt_inc    = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    // zero integer part: saturating counter stands in as a whole amount
    assign stored_amt = int_zero ? {cnt_inc, FRAC_W'(0)} : amt_reg;
    assign scan_last  = (scan_idx_reg == IDX_W'(NUM_SOURCES - 1));
    assign take       = rd_pend_reg && rd_valid_reg
                        && (!found_reg || (rd_amt_reg > best_amt_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode_t'(opcode);
            id_reg  <= source_id;
            amt_reg <= motion_amount;
        end
    end

    // amounts of invalid entries are never looked at, so no clear is needed
    always_ff @(posedge clk)
    begin
        if (cmd.update && in_range && (op_reg == OP_MARK))
        begin
            amount_mem[wr_idx] <= stored_amt;
        end
        if (cmd.scan)
        begin
            rd_amt_reg   <= amount_mem[scan_idx_reg];
            rd_valid_reg <= valid_reg[scan_idx_reg];
            rd_idx_reg   <= scan_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        best_amt_reg <= best_amt_next;
        best_idx_reg <= best_idx_next;
    end

    always_comb
    begin
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        scan_idx_next = scan_idx_reg;
        rd_pend_next  = cmd.scan;
        found_next    = found_reg;
        best_amt_next = best_amt_reg;
        best_idx_next = best_idx_reg;
        if (cmd.update)
        begin
            if (in_range)
            begin
                if (op_reg == OP_MARK)
                begin
                    valid_next[wr_idx] = 1'b1;
                    if (int_zero)
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                else
                begin
                    valid_next[wr_idx] = 1'b0;
                end
            end
            scan_idx_next = '0;
            found_next    = 1'b0;
        end
        else
        begin
            if (cmd.scan)
            begin
                scan_idx_next = scan_last ? '0 : scan_idx_reg + 1'b1;
            end
            // strict greater keeps the lowest index on a tie
            if (take)
            begin
                found_next    = 1'b1;
                best_amt_next = rd_amt_reg;
                best_idx_next = rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            cnt_reg      <= '0;
            scan_idx_reg <= '0;
            rd_pend_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            scan_idx_reg <= scan_idx_next;
            rd_pend_reg  <= rd_pend_next;
            found_reg    <= found_next;
        end
    end

    assign status.scan_last = scan_last;
    assign top_source       = found_reg ? SRC_W'(best_idx_reg) : '0;
    assign table_empty      = !found_reg;

    `MPSS_ASSERT_IMPL(a_best_valid, found_reg, valid_reg[best_idx_reg],
        "winning entry is not valid")
    `MPSS_ASSERT(a_update_clears, cmd.update |=> (!found_reg && (scan_idx_reg == '0)),
        "update did not restart the scan")
    `MPSS_ASSERT(a_cnt_monotonic, 1'b1 |=> (cnt_reg >= $past(cnt_reg)),
        "fallback counter went down")

endmodule

FILE: src/motion_priority_source_selector_core.sv
// Motion priority source selector: one result beat per accepted beat.
// After the accepting edge the core runs an update, a scan of every entry, a flush and the
// result cycle, in which done is high and the result beat is taken at its end.
// busy stays high from update to flush, as the single read port scans one entry at a time.
// A new beat may be started in the cycle the result is shown; the receiver cannot stall.
// Reset (rst_n, async, active low) empties the table and clears the fallback counter.
module motion_priority_source_selector_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       opcode,
    input  logic [mpss_pkg::SRC_W-1:0] source_id,
    input  logic [mpss_pkg::AMT_W-1:0] motion_amount,
    output logic                       done,
    output logic [mpss_pkg::SRC_W-1:0] top_source,
    output logic                       table_empty
);
    import mpss_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mpss_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    mpss_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .opcode        (opcode),
        .source_id     (source_id),
        .motion_amount (motion_amount),
        .status        (status),
        .top_source    (top_source),
        .table_empty   (table_empty)
    );

endmodule

FILE: tb/motion_priority_source_selector_core_tb.sv
module motion_priority_source_selector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mpss_pkg::*;

    localparam int DIR_N       = 25;
    localparam int RANDOM_N    = 1220;
    localparam int AFTER_SAT_N = 60;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = NUM_SOURCES + 8;

    typedef struct packed {
        logic [SRC_W-1:0] top_source;
        logic             table_empty;
    } ranking_t;

    typedef struct packed {
        opcode_t          op;
        logic [SRC_W-1:0] id;
        logic [AMT_W-1:0] amt;
        logic             typed;
        logic [SRC_W-1:0] top;
        logic             empty;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             opcode;
    logic [SRC_W-1:0] source_id;
    logic [AMT_W-1:0] motion_amount;
    logic             done;
    logic [SRC_W-1:0] top_source;
    logic             table_empty;

    // expectation typed into the directed table, travels with the beat
    logic             pin_typed;
    logic [SRC_W-1:0] pin_top;
    logic             pin_empty;

    // shadow of the source table
    logic             src_valid  [NUM_SOURCES];
    logic [AMT_W-1:0] src_amount [NUM_SOURCES];
    logic [CNT_W-1:0] fb_count;

    ranking_t  rank_q [$];
    stim_row_t dir_rows [DIR_N];

    int beats_in;
    int beats_out;
    int mismatches;
    int idle_cycles;
    int n_mark;
    int n_remove;
    int n_zero_int;
    int n_empty;
    bit saturated;

    motion_priority_source_selector_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .source_id     (source_id),
        .motion_amount (motion_amount),
        .done          (done),
        .top_source    (top_source),
        .table_empty   (table_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Updates the shadow table with one beat and returns the highest-ranked source.
    function automatic ranking_t apply_and_rank(opcode_t op, logic [SRC_W-1:0] id,
                                                logic [AMT_W-1:0] amt);
        ranking_t         r;
        logic [AMT_W-1:0] a;
        int               best;
        best = -1;
        if (int'(id) < NUM_SOURCES)
        begin
            if (op == OP_MARK)
            begin
                a = amt;
                if (a[AMT_W-1:FRAC_W] == '0)
                begin
                    if (fb_count != CNT_MAX)
                        fb_count = fb_count + 1'b1;
                    a = {fb_count, {FRAC_W{1'b0}}};
                end
                src_valid[id]  = 1'b1;
                src_amount[id] = a;
            end
            else
            begin
                src_valid[id]  = 1'b0;
                src_amount[id] = '0;
            end
        end
        for (int i = 0; i < NUM_SOURCES; i++)
            if (src_valid[i] && (best < 0 || src_amount[i] > src_amount[best]))
                best = i;
        r.top_source  = (best < 0) ? '0 : SRC_W'(best);
        r.table_empty = (best < 0);
        return r;
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        logic [AMT_W-1:0] a;
        case ($urandom_range(9))
            0, 1: a = {{CNT_W{1'b0}}, FRAC_W'($urandom)};
            2: a = '1;
            3: a = {CNT_W'($urandom_range(1, 3)), {FRAC_W{1'b0}}};
            4: a = {CNT_W'($urandom_range(0, 3) * 16'h5555), FRAC_W'($urandom_range(1))};
            default: a = AMT_W'($urandom);
        endcase
        return a;
    endfunction

    // Holds a beat on the inputs until it is taken; start is left high.
    task automatic send_beat(opcode_t op, logic [SRC_W-1:0] id, logic [AMT_W-1:0] amt,
                             logic typed, logic [SRC_W-1:0] top, logic empty);
        int taken;
        taken = beats_in;
        start         <= 1'b1;
        opcode        <= op;
        source_id     <= id;
        motion_amount <= amt;
        pin_typed     <= typed;
        pin_top       <= top;
        pin_empty     <= empty;
        do
            @(negedge clk);
        while (beats_in == taken);
    endtask

    task automatic maybe_idle(bit allow);
        int gap;
        if (allow && $urandom_range(99) < 27)
        begin
            gap = $urandom_range(1, 50);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_random(bit allow_idle);
        opcode_t op;
        op = ($urandom_range(99) < 62) ? OP_MARK : OP_REMOVE;
        send_beat(op, SRC_W'($urandom_range(NUM_SOURCES - 1)), pick_amount(), 1'b0, '0, 1'b0);
        maybe_idle(allow_idle);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (rank_q.size() != 0)
            @(negedge clk);
    endtask

    // sample at the rising edge: check finished beats, predict accepted ones
    always @(posedge clk)
    begin
        ranking_t want;
        if (rst_n)
        begin
            if (done)
            begin
                beats_out <= beats_out + 1;
                if (rank_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: top_source %0d table_empty %0b",
                                 top_source, table_empty);
                end
                else
                begin
                    want = rank_q.pop_front();
                    if (top_source !== want.top_source || table_empty !== want.table_empty)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: top_source exp %0d got %0d, table_empty exp %0b got %0b",
                                     beats_out, want.top_source, top_source,
                                     want.table_empty, table_empty);
                    end
                end
            end
            if (start && !busy)
            begin
                beats_in <= beats_in + 1;
                if (opcode == OP_MARK)
                begin
                    n_mark++;
                    if (motion_amount[AMT_W-1:FRAC_W] == '0)
                        n_zero_int++;
                end
                else
                    n_remove++;
                want = apply_and_rank(opcode_t'(opcode), source_id, motion_amount);
                if (want.table_empty)
                    n_empty++;
                if (fb_count == CNT_MAX)
                    saturated = 1'b1;
                if (pin_typed)
                begin
                    want.top_source  = pin_top;
                    want.table_empty = pin_empty;
                end
                rank_q.insert(rank_q.size(), want);
            end
        end
    end

    // stall guard: cycles with neither an input nor a result beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, rank_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        rst_n         = 1'b0;
        start         = 1'b0;
        opcode        = OP_MARK;
        source_id     = '0;
        motion_amount = '0;
        pin_typed     = 1'b0;
        pin_top       = '0;
        pin_empty     = 1'b0;
        fb_count      = '0;
        beats_in      = 0;
        beats_out     = 0;
        mismatches    = 0;
        idle_cycles   = 0;
        n_mark        = 0;
        n_remove      = 0;
        n_zero_int    = 0;
        n_empty       = 0;
        saturated     = 1'b0;
        for (i = 0; i < NUM_SOURCES; i++)
        begin
            src_valid[i]  = 1'b0;
            src_amount[i] = '0;
        end

        // op, source, amount, typed, top, empty
        dir_rows = '{
            '{OP_REMOVE, 4'd0,  24'h000000, 1'b1, 4'd0,  1'b1}, // remove on empty table
            '{OP_MARK,   4'd15, 24'hFFFFFF, 1'b1, 4'd15, 1'b0},
            '{OP_MARK,   4'd0,  24'hFFFFFF, 1'b1, 4'd0,  1'b0}, // tie, low index wins
            '{OP_MARK,   4'd3,  24'h000000, 1'b1, 4'd0,  1'b0}, // zero integer part
            '{OP_MARK,   4'd4,  24'h0000FF, 1'b1, 4'd0,  1'b0},
            '{OP_REMOVE, 4'd0,  24'hABCDEF, 1'b1, 4'd15, 1'b0}, // amount ignored
            '{OP_REMOVE, 4'd15, 24'h000000, 1'b0, 4'd0,  1'b0},
            '{OP_MARK,   4'd5,  24'h000100, 1'b0, 4'd0,  1'b0},
            '{OP_MARK,   4'd4,  24'h000001, 1'b0, 4'd0,  1'b0}, // replace via counter
            '{OP_REMOVE, 4'd7,  24'hFFFFFF, 1'b0, 4'd0,  1'b0}, // entry not valid
            '{OP_MARK,   4'd9,  24'h800000, 1'b0, 4'd0,  1'b0},
            '{OP_MARK,   4'd9,  24'h7FFFFF, 1'b0, 4'd0,  1'b0}, // replace with smaller
            '{OP_MARK,   4'd2,  24'h7FFFFF, 1'b0, 4'd0,  1'b0},
            '{OP_REMOVE, 4'd9,  24'h000000, 1'b0, 4'd0,  1'b0},
            '{OP_REMOVE, 4'd2,  24'h000000, 1'b0, 4'd0,  1'b0},
            '{OP_REMOVE, 4'd3,  24'h000000, 1'b0, 4'd0,  1'b0},
            '{OP_REMOVE, 4'd4,  24'h000000, 1'b0, 4'd0,  1'b0},
            '{OP_REMOVE, 4'd5,  24'h000000, 1'b1, 4'd0,  1'b1},
            '{OP_MARK,   4'd1,  24'h000000, 1'b0, 4'd0,  1'b0},
            '{OP_MARK,   4'd1,  24'hFFFF00, 1'b0, 4'd0,  1'b0},
            '{OP_REMOVE, 4'd1,  24'h000000, 1'b1, 4'd0,  1'b1},
            '{OP_MARK,   4'd8,  24'h555555, 1'b0, 4'd0,  1'b0},
            '{OP_MARK,   4'd6,  24'hAAAAAA, 1'b0, 4'd0,  1'b0},
            '{OP_REMOVE, 4'd6,  24'h000000, 1'b0, 4'd0,  1'b0},
            '{OP_REMOVE, 4'd8,  24'h000000, 1'b1, 4'd0,  1'b1}
        };

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < DIR_N; i++)
        begin
            send_beat(dir_rows[i].op, dir_rows[i].id, dir_rows[i].amt,
                      dir_rows[i].typed, dir_rows[i].top, dir_rows[i].empty);
            maybe_idle(1'b1);
        end

        for (i = 0; i < RANDOM_N; i++)
        begin
            if (i == 300 || i == 1000)
            begin
                // hold off until the pipe is empty
                send_beat(OP_MARK, SRC_W'($urandom_range(NUM_SOURCES - 1)), pick_amount(),
                          1'b0, '0, 1'b0);
                drain();
            end
            else
                send_random(!(i >= 500 && i < 800));
        end

        // counter-derived amounts against the largest explicit amounts
        for (i = 0; i < AFTER_SAT_N; i++)
        begin
            if (i % 4 == 0)
                send_beat(OP_MARK, SRC_W'($urandom_range(NUM_SOURCES - 1)),
                          (i % 8 == 0) ? 24'hFFFF00 : 24'hFFFFFF, 1'b0, '0, 1'b0);
            else if (i % 4 == 1)
                send_beat(OP_MARK, SRC_W'($urandom_range(NUM_SOURCES - 1)),
                          {{CNT_W{1'b0}}, FRAC_W'($urandom)}, 1'b0, '0, 1'b0);
            else
                send_random(1'b1);
        end

        start <= 1'b0;
        while (rank_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (rank_q.size() != 0)
        begin
            $display("%0d expected results never arrived", rank_q.size());
            mismatches += rank_q.size();
        end

        $display("Covered %0d beats: %0d marks (%0d with zero integer part), %0d removes.",
                 beats_in, n_mark, n_zero_int, n_remove);
        $display("%0d results on an empty table; fallback counter saturated: %0s; %0d mismatches.",
                 n_empty, saturated ? "yes" : "no", mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
